// File: hdl/gradient_noise_turbulence_unit_assert.svh
// assertion macros shared by the noise unit
`ifndef GRADIENT_NOISE_TURBULENCE_UNIT_ASSERT_SVH
`define GRADIENT_NOISE_TURBULENCE_UNIT_ASSERT_SVH
// same-cycle implication, checked outside reset
`define GNT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define GNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/gnt_pkg.sv
// types and constants of the gradient noise turbulence unit
`timescale 1ns / 1ps
package gnt_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_LOAD_PERM = 2'd0;
  localparam logic [1:0] OP_LOAD_GRAD = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_OCTAVES  = 2'd1;
  localparam logic [1:0] REG_START    = 2'd2;

  // fixed field widths
  localparam int POINT_W     = 32;
  localparam int GRAD_W      = 16;
  localparam int PERM_W      = 8;
  localparam int START_W     = 16;
  localparam int FREQ_W      = 32;
  localparam int OCT_CMP_W   = 6;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // fixed-point shifts: frequency is q8.24, gradients q1.14
  localparam int FREQ_FRAC   = 24;
  localparam int START_SHIFT = 8;
  localparam int DOT_SHIFT   = 14;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_OCT,
    ST_SETUP,
    ST_CORNER,
    ST_LERP,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } gnt_state_t;

endpackage

// File: hdl/gradient_noise_turbulence_unit.sv
// Gradient noise turbulence unit: 3d lattice gradient noise summed over octaves.
// A load beat (permutation or gradient entry) is written into its table as it is taken. An evaluate
// beat runs one octave at a time on a single shared signed multiplier: an octave check,
// permutation reads and smoothstep weights, gradient dot products for each of the eight
// corners and trilinear blending. In mode 0 an octave ends with an accumulate. In mode 1
// three multiplies scale the point first and each octave adds a bit-serial division, at
// most 8 octaves.
// The result sits in an output register; a new beat is taken while it waits.
`timescale 1ns / 1ps
`include "gradient_noise_turbulence_unit_assert.svh"
module gradient_noise_turbulence_unit #(
  parameter int TABLE_SIZE    = 256,
  parameter int MAX_OCTAVES   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [7:0]          table_index,
  input  logic [7:0]          perm_value,
  input  logic signed [15:0]  grad_x,
  input  logic signed [15:0]  grad_y,
  input  logic signed [15:0]  grad_z,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  noise_sum,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int FB   = FRACTION_BITS;
  localparam int IW   = $clog2(TABLE_SIZE);
  localparam int NW   = FB + 4;
  localparam int AW   = FB + 19;
  localparam int MA   = (NW + 1 > gnt_pkg::POINT_W + 1) ? NW + 1 : gnt_pkg::POINT_W + 1;
  localparam int MB   = (FB + 3 > gnt_pkg::START_W + 1) ? FB + 3 : gnt_pkg::START_W + 1;
  localparam int MP   = MA + MB;
  localparam int CW   = FB + IW;
  localparam int PK   = gnt_pkg::POINT_W + gnt_pkg::START_W + 1 - gnt_pkg::START_SHIFT;
  localparam int PW   = (CW > PK) ? CW : PK;
  localparam int DW   = NW + gnt_pkg::FREQ_FRAC;
  localparam int DCW  = $clog2(DW);
  localparam int KW   = $clog2(MAX_OCTAVES + 1);
  localparam int SW   = (NW + KW + 4 > 33) ? NW + KW + 4 : 33;
  localparam int GW   = 3 * gnt_pkg::GRAD_W;

  // configuration registers
  logic                            turbulence_mode;
  logic [4:0]                      octave_count;
  logic [gnt_pkg::START_W-1:0]     start_frequency;

  // sequencer
  gnt_pkg::gnt_state_t             state, state_next;
  logic [2:0]                      step;
  logic [2:0]                      sub;
  logic [DCW-1:0]                  dcnt;
  logic [KW-1:0]                   k;

  // datapath registers
  logic signed [gnt_pkg::POINT_W-1:0] pt [3];
  logic signed [PW-1:0]            sp [3];
  logic [gnt_pkg::FREQ_W-1:0]      fq;
  logic signed [SW-1:0]            sum;
  logic [gnt_pkg::PERM_W-1:0]      pi, pj;
  logic [gnt_pkg::PERM_W-1:0]      hb [4];
  logic [FB:0]                     sw [3];
  logic signed [AW-1:0]            acc;
  logic signed [NW-1:0]            q [8];
  logic signed [MP-1:0]            prod;
  logic [DW-1:0]                   dq;
  logic [gnt_pkg::FREQ_W-1:0]      rem;

  // memories
  logic [gnt_pkg::PERM_W-1:0]      perm_mem [TABLE_SIZE];
  logic [GW-1:0]                   grad_mem [TABLE_SIZE];
  logic [gnt_pkg::PERM_W-1:0]      perm_rdata;
  logic [GW-1:0]                   grad_rdata;
  logic [IW-1:0]                   perm_raddr, grad_raddr;
  logic                            grad_re;

  // combinational helpers
  logic signed [MA-1:0]            mul_a;
  logic signed [MB-1:0]            mul_b;
  logic [IW-1:0]                   cell0 [3];
  logic [IW-1:0]                   cell1 [3];
  logic [FB-1:0]                   frac [3];
  logic [FB-1:0]                   frac_sel;
  logic signed [gnt_pkg::POINT_W-1:0] pt_sel;
  logic [FB+1:0]                   blend_k;
  logic [FB:0]                     s_sel;
  logic signed [NW:0]              diff;
  logic signed [NW-1:0]            lerp_val;
  logic signed [NW-1:0]            dot_val;
  logic [NW-1:0]                   mag;
  logic [gnt_pkg::FREQ_W:0]        trial;
  logic                            qbit;
  logic [2:0]                      widx;
  logic [gnt_pkg::OCT_CMP_W-1:0]   oct_limit;
  logic                            octave_go;
  logic                            in_beat;
  logic                            cfg_write;
  logic [SW-32:0]                  sum_upper;

  assign in_beat   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      turbulence_mode <= 1'b0;
      octave_count    <= 5'd4;
      start_frequency <= 16'd256;
    end else if (cfg_write) begin
      case (paddr[3:2])
        gnt_pkg::REG_MODE:    turbulence_mode <= pwdata[0];
        gnt_pkg::REG_OCTAVES: octave_count    <= pwdata[4:0];
        gnt_pkg::REG_START:   start_frequency <= pwdata[gnt_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    case (paddr[3:2])
      gnt_pkg::REG_MODE:    prdata = {31'd0, turbulence_mode};
      gnt_pkg::REG_OCTAVES: prdata = {27'd0, octave_count};
      gnt_pkg::REG_START:   prdata = {16'd0, start_frequency};
      default:              prdata = '0;
    endcase
  end

  // permutation table
  always_ff @(posedge clk) begin
    if (in_beat && operation == gnt_pkg::OP_LOAD_PERM) begin
      perm_mem[IW'(table_index)] <= perm_value;
    end
    perm_rdata <= perm_mem[perm_raddr];
  end

  // gradient table, packed x y z
  always_ff @(posedge clk) begin
    if (in_beat && operation == gnt_pkg::OP_LOAD_GRAD) begin
      grad_mem[IW'(table_index)] <= {grad_x, grad_y, grad_z};
    end
    if (grad_re) begin
      grad_rdata <= grad_mem[grad_raddr];
    end
  end

  // lattice cell and fraction of the scaled point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell0[a] = sp[a][FB+IW-1:FB];
      cell1[a] = cell0[a] + IW'(1);
      frac[a]  = sp[a][FB-1:0];
    end
  end

  // per-step operand picks
  always_comb begin
    case (step[2:1])
      2'd0:    frac_sel = frac[0];
      2'd1:    frac_sel = frac[1];
      default: frac_sel = frac[2];
    endcase
    case (step[1:0])
      2'd0:    pt_sel = pt[0];
      2'd1:    pt_sel = pt[1];
      default: pt_sel = pt[2];
    endcase
    if (step < 3'd4) begin
      s_sel = sw[0];
    end else if (step < 3'd6) begin
      s_sel = sw[1];
    end else begin
      s_sel = sw[2];
    end
    blend_k  = {2'b11, {FB{1'b0}}} - {1'b0, frac_sel, 1'b0};
    diff     = (NW+1)'(q[1]) - (NW+1)'(q[0]);
    lerp_val = NW'(q[0] + (prod >>> FB));
    dot_val  = NW'((acc + AW'(prod)) >>> gnt_pkg::DOT_SHIFT);
    mag      = q[0][NW-1] ? NW'(-q[0]) : q[0];
    trial    = {rem, dq[DW-1]} - {1'b0, fq};
    qbit     = !trial[gnt_pkg::FREQ_W];
    widx     = 3'd6 - step;
    oct_limit = (gnt_pkg::OCT_CMP_W'(octave_count) > gnt_pkg::OCT_CMP_W'(MAX_OCTAVES)) ?
                gnt_pkg::OCT_CMP_W'(MAX_OCTAVES) : gnt_pkg::OCT_CMP_W'(octave_count);
    octave_go = turbulence_mode ?
                (fq[gnt_pkg::FREQ_W-1:gnt_pkg::FREQ_FRAC] != '0) :
                (gnt_pkg::OCT_CMP_W'(k) < oct_limit);
    sum_upper = sum[SW-1:31];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gnt_pkg::ST_IDLE: begin
        if (in_beat && operation == gnt_pkg::OP_EVAL) begin
          state_next = turbulence_mode ? gnt_pkg::ST_SCALE : gnt_pkg::ST_OCT;
        end
      end
      gnt_pkg::ST_SCALE:  if (step == 3'd3) state_next = gnt_pkg::ST_OCT;
      gnt_pkg::ST_OCT:    state_next = octave_go ? gnt_pkg::ST_SETUP : gnt_pkg::ST_DONE;
      gnt_pkg::ST_SETUP:  if (step == 3'd7) state_next = gnt_pkg::ST_CORNER;
      gnt_pkg::ST_CORNER: if (step == 3'd7 && sub == 3'd4) state_next = gnt_pkg::ST_LERP;
      gnt_pkg::ST_LERP:   if (step == 3'd6 && sub[0]) state_next = gnt_pkg::ST_ACC;
      gnt_pkg::ST_ACC:    state_next = turbulence_mode ? gnt_pkg::ST_DIV : gnt_pkg::ST_OCT;
      gnt_pkg::ST_DIV:    if (dcnt == DCW'(DW - 1)) state_next = gnt_pkg::ST_OCT;
      gnt_pkg::ST_DONE:   if (!out_valid || out_ready) state_next = gnt_pkg::ST_IDLE;
      default:            state_next = gnt_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, memory reads, multiplier operands
  always_comb begin
    in_ready   = (state == gnt_pkg::ST_IDLE);
    perm_raddr = cell0[0];
    grad_raddr = IW'(hb[step[1:0]]) + (step[2] ? cell1[2] : cell0[2]);
    grad_re    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      gnt_pkg::ST_SCALE: begin
        mul_a = MA'(pt_sel);
        mul_b = MB'({1'b0, start_frequency});
      end
      gnt_pkg::ST_SETUP: begin
        case (step)
          3'd0:    perm_raddr = cell0[0];
          3'd1:    perm_raddr = cell1[0];
          default: perm_raddr = IW'(step[0] ? pj : pi) + (step[2] ? cell1[1] : cell0[1]);
        endcase
        if (!step[0]) begin
          mul_a = MA'({1'b0, frac_sel});
          mul_b = MB'({1'b0, frac_sel});
        end else begin
          mul_a = MA'({1'b0, prod[2*FB-1:FB]});
          mul_b = MB'({1'b0, blend_k});
        end
      end
      gnt_pkg::ST_CORNER: begin
        grad_re = (sub == 3'd0);
        case (sub)
          3'd1: begin
            mul_a = MA'($signed({step[0], frac[0]}));
            mul_b = MB'($signed(grad_rdata[GW-1:2*gnt_pkg::GRAD_W]));
          end
          3'd2: begin
            mul_a = MA'($signed({step[1], frac[1]}));
            mul_b = MB'($signed(grad_rdata[2*gnt_pkg::GRAD_W-1:gnt_pkg::GRAD_W]));
          end
          3'd3: begin
            mul_a = MA'($signed({step[2], frac[2]}));
            mul_b = MB'($signed(grad_rdata[gnt_pkg::GRAD_W-1:0]));
          end
          default: ;
        endcase
      end
      gnt_pkg::ST_LERP: begin
        mul_a = MA'(diff);
        mul_b = MB'({1'b0, s_sel});
      end
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gnt_pkg::ST_IDLE;
      step      <= '0;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        gnt_pkg::ST_IDLE: begin
          step <= '0;
          sub  <= '0;
        end
        gnt_pkg::ST_SCALE,
        gnt_pkg::ST_SETUP: step <= (state_next == state) ? step + 3'd1 : 3'd0;
        gnt_pkg::ST_OCT: begin
          step <= '0;
          sub  <= '0;
        end
        gnt_pkg::ST_CORNER: begin
          if (sub == 3'd4) begin
            sub  <= '0;
            step <= step + 3'd1;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        gnt_pkg::ST_LERP: begin
          sub[0] <= !sub[0];
          if (sub[0]) begin
            step <= (step == 3'd6) ? 3'd0 : step + 3'd1;
          end
        end
        gnt_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      gnt_pkg::ST_IDLE: begin
        pt[0] <= point_x;
        pt[1] <= point_y;
        pt[2] <= point_z;
        sp[0] <= PW'(point_x);
        sp[1] <= PW'(point_y);
        sp[2] <= PW'(point_z);
        fq    <= {start_frequency, 16'd0};
        k     <= '0;
        sum   <= '0;
      end
      gnt_pkg::ST_SCALE: begin
        // product of the previous step is the scaled coordinate
        if (step != 3'd0) begin
          sp[step[1:0] - 2'd1] <= PW'(prod >>> gnt_pkg::START_SHIFT);
        end
      end
      gnt_pkg::ST_SETUP: begin
        if (step == 3'd1) pi <= perm_rdata;
        if (step == 3'd2) pj <= perm_rdata;
        // corner hashes read at steps 2 to 5 are captured at the following step
        if (step >= 3'd3 && step <= 3'd6) hb[2'(step - 3'd3)] <= perm_rdata;
        if (!step[0] && step != 3'd0) begin
          sw[step[2:1] - 2'd1] <= prod[2*FB:FB];
        end
      end
      gnt_pkg::ST_CORNER: begin
        case (sub)
          3'd2: acc <= AW'(prod);
          3'd3: acc <= acc + AW'(prod);
          3'd4: begin
            for (int i = 0; i < 7; i++) begin
              q[i] <= q[i+1];
            end
            q[7] <= dot_val;
          end
          default: ;
        endcase
      end
      gnt_pkg::ST_LERP: begin
        // pop two, push the blend at the tail
        if (sub[0]) begin
          for (int i = 0; i < 8; i++) begin
            if (3'(i) == widx) begin
              q[i] <= lerp_val;
            end else if (i < 6) begin
              q[i] <= q[(i < 6) ? i + 2 : i];
            end
          end
        end
      end
      gnt_pkg::ST_ACC: begin
        if (turbulence_mode) begin
          dq   <= {mag, {gnt_pkg::FREQ_FRAC{1'b0}}};
          rem  <= '0;
          dcnt <= '0;
        end else begin
          sum <= sum + SW'(q[0] >>> k);
          k   <= k + KW'(1);
          for (int a = 0; a < 3; a++) begin
            sp[a] <= sp[a] <<< 1;
          end
        end
      end
      gnt_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        rem  <= qbit ? trial[gnt_pkg::FREQ_W-1:0] : {rem[gnt_pkg::FREQ_W-2:0], dq[DW-1]};
        dq   <= {dq[DW-2:0], qbit};
        dcnt <= dcnt + DCW'(1);
        if (dcnt == DCW'(DW - 1)) begin
          sum <= sum + SW'({dq[DW-2:0], qbit});
          fq  <= fq >> 1;
          for (int a = 0; a < 3; a++) begin
            sp[a] <= sp[a] >>> 1;
          end
        end
      end
      gnt_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          if (!(&sum_upper) && (|sum_upper)) begin
            noise_sum <= sum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            noise_sum <= sum[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // checks
  `GNT_ASSERT_NEXT(a_eval_starts, in_valid && in_ready && operation == gnt_pkg::OP_EVAL, state != gnt_pkg::ST_IDLE, "evaluate beat did not start work")
  `GNT_ASSERT_NEXT(a_done_posts, state == gnt_pkg::ST_DONE && !out_valid, out_valid, "finished sum not posted")
  `GNT_ASSERT_NEXT(a_load_silent, in_valid && in_ready && operation != gnt_pkg::OP_EVAL && !out_valid, !out_valid, "load beat produced a result")
  `GNT_ASSERT_SAME(a_ready_idle, in_ready, !(state == gnt_pkg::ST_DIV || state == gnt_pkg::ST_CORNER), "ready while busy")

endmodule

// File: tb/gnt_noise_checker.sv
// checker for the noise unit: tracks tables and registers, predicts and compares sums
`timescale 1ns / 1ps
module gnt_noise_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         table_index,
  input  logic [7:0]         perm_value,
  input  logic signed [15:0] grad_x,
  input  logic signed [15:0] grad_y,
  input  logic signed [15:0] grad_z,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] noise_sum,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam int FB = 16;
  localparam int OCT_LIMIT = 16;
  localparam longint ONE = 64'sd1 << FB;

  // shadow copies of the lattice tables and registers
  logic [7:0]         perm_tab [256];
  logic signed [15:0] gx_tab [256];
  logic signed [15:0] gy_tab [256];
  logic signed [15:0] gz_tab [256];
  logic               mode_r;
  logic [4:0]         oct_r;
  logic [15:0]        start_r;
  logic signed [31:0] sums_due [$];

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  function automatic longint fade(longint t);
    longint t2;
    t2 = (t * t) >>> FB;
    return (t2 * (3 * ONE - 2 * t)) >>> FB;
  endfunction

  function automatic longint mix(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> FB);
  endfunction

  // gradient at a hashed corner dotted with the offset, floored to the fraction
  function automatic longint grad_dot(int idx, longint rx, longint ry, longint rz);
    longint gxl, gyl, gzl;
    gxl = gx_tab[idx & 255];
    gyl = gy_tab[idx & 255];
    gzl = gz_tab[idx & 255];
    return (rx * gxl + ry * gyl + rz * gzl) >>> 14;
  endfunction

  function automatic longint cell_noise(logic [63:0] sx, logic [63:0] sy, logic [63:0] sz);
    int bx0, bx1, by0, by1, bz0, bz1, i, j, b00, b10, b01, b11;
    longint rx0, rx1, ry0, ry1, rz0, rz1, wx, wy, wz, a, b, c, d;
    bx0 = int'((sx >> FB) & 64'hFF);
    by0 = int'((sy >> FB) & 64'hFF);
    bz0 = int'((sz >> FB) & 64'hFF);
    bx1 = (bx0 + 1) & 255;
    by1 = (by0 + 1) & 255;
    bz1 = (bz0 + 1) & 255;
    rx0 = sx & 64'hFFFF;
    ry0 = sy & 64'hFFFF;
    rz0 = sz & 64'hFFFF;
    rx1 = rx0 - ONE;
    ry1 = ry0 - ONE;
    rz1 = rz0 - ONE;
    i = perm_tab[bx0];
    j = perm_tab[bx1];
    b00 = perm_tab[(i + by0) & 255];
    b10 = perm_tab[(j + by0) & 255];
    b01 = perm_tab[(i + by1) & 255];
    b11 = perm_tab[(j + by1) & 255];
    wx = fade(rx0);
    wy = fade(ry0);
    wz = fade(rz0);
    a = mix(wx, grad_dot(b00 + bz0, rx0, ry0, rz0), grad_dot(b10 + bz0, rx1, ry0, rz0));
    b = mix(wx, grad_dot(b01 + bz0, rx0, ry1, rz0), grad_dot(b11 + bz0, rx1, ry1, rz0));
    c = mix(wy, a, b);
    a = mix(wx, grad_dot(b00 + bz1, rx0, ry0, rz1), grad_dot(b10 + bz1, rx1, ry0, rz1));
    b = mix(wx, grad_dot(b01 + bz1, rx0, ry1, rz1), grad_dot(b11 + bz1, rx1, ry1, rz1));
    d = mix(wy, a, b);
    return mix(wz, c, d);
  endfunction

  // octave sum for one point under the current registers, saturated once
  function automatic logic signed [31:0] turbulence_sum(logic signed [31:0] x,
                                                         logic signed [31:0] y,
                                                         logic signed [31:0] z);
    longint px, py, pz, acc, f, v;
    logic [63:0] fq, mag, ux, uy, uz;
    int n;
    px = x;
    py = y;
    pz = z;
    acc = 0;
    if (mode_r == 1'b0) begin
      n = (oct_r > OCT_LIMIT) ? OCT_LIMIT : int'(oct_r);
      for (int k = 0; k < n; k++) begin
        ux = px;
        uy = py;
        uz = pz;
        v = cell_noise(ux << k, uy << k, uz << k);
        acc += v >>> k;
      end
    end else begin
      fq = 64'(start_r) << 16;
      while (fq >= 64'h100_0000) begin
        f = longint'(fq);
        ux = px * f;
        uy = py * f;
        uz = pz * f;
        v = cell_noise(ux >> 24, uy >> 24, uz >> 24);
        mag = (v < 0) ? 64'(-v) : 64'(v);
        acc += longint'((mag << 24) / fq);
        fq = fq >> 1;
      end
    end
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(acc);
  endfunction

  // watch the register port, the input beats and the result beats
  always @(posedge clk) begin
    if (rst) begin
      mode_r = 1'b0;
      oct_r = 5'd4;
      start_r = 16'd256;
      sums_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          gnt_pkg::REG_MODE:    mode_r = pwdata[0];
          gnt_pkg::REG_OCTAVES: oct_r = pwdata[4:0];
          gnt_pkg::REG_START:   start_r = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        checked++;
        if (sums_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("noise_sum beat with nothing expected: actual %0d", noise_sum);
        end else begin
          if (noise_sum !== sums_due[0]) begin
            errors++;
            if (errors <= 10)
              $display("noise_sum mismatch: expected %0d actual %0d", sums_due[0], noise_sum);
          end
          void'(sums_due.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        case (operation)
          gnt_pkg::OP_LOAD_PERM: perm_tab[table_index] = perm_value;
          gnt_pkg::OP_LOAD_GRAD: begin
            gx_tab[table_index] = grad_x;
            gy_tab[table_index] = grad_y;
            gz_tab[table_index] = grad_z;
          end
          gnt_pkg::OP_EVAL: sums_due.push_back(turbulence_sum(point_x, point_y, point_z));
          default: ;
        endcase
      end
    end
    pending = sums_due.size();
  end

endmodule

// File: tb/gradient_noise_turbulence_unit_tb.sv
// testbench top for the noise unit: table set-up, directed and random beats, verdict
`timescale 1ns / 1ps
module gradient_noise_turbulence_unit_tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = '0;
  logic [7:0]         table_index = '0;
  logic [7:0]         perm_value = '0;
  logic signed [15:0] grad_x = '0;
  logic signed [15:0] grad_y = '0;
  logic signed [15:0] grad_z = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] noise_sum;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int errors, pending, checked;
  int cycles = 0;
  int beats_sent = 0;
  bit no_gaps = 1'b0;
  bit sink_free = 1'b0;
  int stall_left = 0;
  logic [7:0] shuffle [256];

  gradient_noise_turbulence_unit dut (.*);

  gnt_noise_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .operation, .table_index, .perm_value,
    .grad_x, .grad_y, .grad_z, .point_x, .point_y, .point_z,
    .out_valid, .out_ready, .noise_sum, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata, .errors, .pending, .checked
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("gradient_noise_turbulence_unit verification failed");
      $finish;
    end
  end

  // result side backpressure: mostly ready, short and occasional long stalls
  always @(posedge clk) begin
    if (rst || sink_free) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:84]:  out_ready <= 1'b1;
        [85:96]: begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end
        default: begin
          stall_left = $urandom_range(20, 60);
          out_ready <= 1'b0;
        end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input beat; returns at the edge that accepts it
  task automatic send_beat(logic [1:0] op, logic [7:0] idx, logic [7:0] pv,
                           logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    table_index <= idx;
    perm_value <= pv;
    grad_x <= gx;
    grad_y <= gy;
    grad_z <= gz;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic eval_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_beat(gnt_pkg::OP_EVAL, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), px, py, pz);
  endtask

  // stop sending and wait until every sum has come back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic mode, logic [4:0] oct, logic [15:0] start);
    drain();
    reg_write(gnt_pkg::REG_MODE, {31'd0, mode});
    reg_write(gnt_pkg::REG_OCTAVES, {27'd0, oct});
    reg_write(gnt_pkg::REG_START, {16'd0, start});
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    if (r < 80) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_grad();
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      send_beat(gnt_pkg::OP_LOAD_PERM, 8'($urandom), 8'($urandom), '0, '0, '0, '0, '0, '0);
    else if (r < 24)
      send_beat(gnt_pkg::OP_LOAD_GRAD, 8'($urandom), 8'($urandom), rand_grad(), rand_grad(),
                rand_grad(), $urandom, $urandom, $urandom);
    else if (r < 95)
      eval_point(rand_coord(), rand_coord(), rand_coord());
    else
      send_beat(OP_IGNORED, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int j;
    logic [7:0] tmp;
    logic [15:0] start_pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill both tables so no unwritten entry is ever read
    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send_beat(gnt_pkg::OP_LOAD_PERM, 8'(i), shuffle[i], '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 256; i++)
      send_beat(gnt_pkg::OP_LOAD_GRAD, 8'(i), '0, rand_grad(), rand_grad(), rand_grad(),
                '0, '0, '0);

    // directed: field extremes, ignored operation, load extremes, register corners
    eval_point(32'h0, 32'h0, 32'h0);
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'hFFFF_8000, 32'hFFFE_4000);
    eval_point(32'h0000_8000, 32'h00FF_C000, 32'hFF00_0001);
    send_beat(OP_IGNORED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(gnt_pkg::OP_LOAD_PERM, 8'd0, 8'hFF, '0, '0, '0, '0, '0, '0);
    send_beat(gnt_pkg::OP_LOAD_PERM, 8'hFF, 8'd0, '0, '0, '0, '0, '0, '0);
    send_beat(gnt_pkg::OP_LOAD_GRAD, 8'd0, '0, 16'hC000, 16'h4000, 16'h3FFF, '0, '0, '0);
    send_beat(gnt_pkg::OP_LOAD_GRAD, 8'hFF, '0, 16'h4000, 16'hC000, 16'hC000, '0, '0, '0);
    eval_point(32'h00FF_FFFF, 32'h0000_0000, 32'hFFFF_0000);
    set_config(1'b0, 5'd0, 16'd256);
    eval_point(32'h0001_2345, 32'h0002_0000, 32'hFFFF_1000);
    set_config(1'b0, 5'd31, 16'd256);
    eval_point(32'h0001_2345, 32'h8000_0000, 32'h7FFF_FFFF);
    set_config(1'b1, 5'd1, 16'd0);
    eval_point(32'h0001_2345, 32'h0002_0000, 32'hFFFF_1000);
    set_config(1'b1, 5'd1, 16'd255);
    eval_point(32'h0001_2345, 32'h0002_0000, 32'hFFFF_1000);
    set_config(1'b1, 5'd16, 16'd256);
    eval_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
    set_config(1'b1, 5'd16, 16'hFFFF);
    eval_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      start_pick = 16'($urandom_range(256, 2048));
      case (ph)
        0: set_config(1'b0, 5'd1, 16'($urandom));
        1: set_config(1'b0, 5'd4, 16'($urandom));
        2: set_config(1'b0, 5'($urandom_range(2, 6)), 16'($urandom));
        3: set_config(1'b1, 5'($urandom), 16'd256);
        4: set_config(1'b0, 5'd16, 16'($urandom));
        5: set_config(1'b1, 5'($urandom), 16'hFFFF);
        6: set_config(1'b1, 5'($urandom), start_pick);
        default: set_config(1'b0, 5'($urandom_range(1, 3)), 16'($urandom));
      endcase
      no_gaps = (ph % 4 == 3);
      sink_free = (ph % 4 == 1);
      for (int i = 0; i < 35; i++) begin
        if (ph == 2 && i == 17) drain();
        random_beat();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("sent %0d beats (table fill, directed, random) and checked %0d sums", beats_sent,
             checked);
    $display("covered both modes, octave counts 0 to 31, start frequencies 0 to 65535");
    if (errors == 0 && pending == 0)
      $display("gradient_noise_turbulence_unit verification clean");
    else
      $display("gradient_noise_turbulence_unit verification failed");
    $finish;
  end

endmodule
